// ----- hw/rtl/ssq_pkg.sv -----
// ssq_pkg: shared types and constants for the stepper step sequencer
// no dependencies

package ssq_pkg;

  localparam int POS_W       = 16;
  localparam int DELAY_W     = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int TIMER_W_DEF = 24;

  localparam logic [POS_W-1:0]   SPR_RESET   = 16'd200;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd6000;

  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY_US = 2'd1;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_MOVE = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]   steps_per_rev;
    logic [DELAY_W-1:0] step_delay_us;
  } cfg_t;

  typedef struct packed {
    logic             coil_a;
    logic             coil_b;
    logic             stepped;
    logic             busy_res;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] remaining;
  } res_t;

endpackage

// ----- hw/rtl/ssq_in_if.sv -----
// ssq_in_if: input item channel (valid/ready with action and move_steps)
// depends on ssq_pkg

interface ssq_in_if;
  import ssq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [POS_W-1:0] move_steps;

  modport source (output valid, action, move_steps, input ready);
  modport sink (input valid, action, move_steps, output ready);
endinterface

// ----- hw/rtl/ssq_out_if.sv -----
// ssq_out_if: result channel (valid/ready with coil levels and motion status)
// depends on ssq_pkg

interface ssq_out_if;
  import ssq_pkg::*;

  logic             valid;
  logic             ready;
  logic             coil_a;
  logic             coil_b;
  logic             stepped;
  logic             busy_res;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] remaining;

  modport source (output valid, coil_a, coil_b, stepped, busy_res, position, remaining,
                  input ready);
  modport sink (input valid, coil_a, coil_b, stepped, busy_res, position, remaining,
                output ready);
endinterface

// ----- hw/rtl/ssq_cfg_if.sv -----
// ssq_cfg_if: configuration write channel (valid/ready, register index, data)
// depends on ssq_pkg

interface ssq_cfg_if;
  import ssq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ssq_cfg_regs.sv -----
// ssq_cfg_regs: steps per revolution and step delay registers
// depends on ssq_pkg

module ssq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [ssq_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ssq_pkg::CFG_DATA_W-1:0] wr_data,
  output ssq_pkg::cfg_t                  cfg
);
  import ssq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_STEPS_PER_REV: cfg_nxt.steps_per_rev = wr_data[POS_W-1:0];
        CFG_STEP_DELAY_US: cfg_nxt.step_delay_us = wr_data[DELAY_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steps_per_rev <= SPR_RESET;
      cfg_r.step_delay_us <= DELAY_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

// ----- hw/rtl/ssq_motion.sv -----
// ssq_motion: motion state (position, direction, pending steps, elapsed timer)
// and the per-beat step decision; depends on ssq_pkg

module ssq_motion #(
  parameter int TIMER_WIDTH = ssq_pkg::TIMER_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           action,
  input  logic signed [ssq_pkg::POS_W-1:0] move_steps,
  input  ssq_pkg::cfg_t                  cfg,
  output ssq_pkg::res_t                  res
);
  import ssq_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > DELAY_W) ? TIMER_WIDTH : DELAY_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   fwd_r, fwd_nxt;
  logic [POS_W-1:0]       pend_r, pend_nxt;
  logic [TIMER_WIDTH-1:0] elapsed_r, elapsed_nxt;

  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic [POS_W-1:0]       rev;
  logic [POS_W-1:0]       pos_adv;
  logic [POS_W:0]         pos_plus;
  logic                   take_step;

  always_comb begin
    rev      = (cfg.steps_per_rev == '0) ? POS_W'(1) : cfg.steps_per_rev;
    pos_plus = {1'b0, pos_r} + (POS_W+1)'(1);
    if (fwd_r) begin
      pos_adv = (pos_plus >= {1'b0, rev}) ? '0 : pos_plus[POS_W-1:0];
    end else begin
      pos_adv = (pos_r == '0 || pos_r >= rev) ? rev - POS_W'(1) : pos_r - POS_W'(1);
    end

    elapsed_inc = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + TIMER_WIDTH'(1);
    take_step   = (pend_r != '0)
               && ((CMP_W'(elapsed_inc) >= CMP_W'(cfg.step_delay_us))
                   || (elapsed_inc == TIMER_MAX));

    pos_nxt     = pos_r;
    fwd_nxt     = fwd_r;
    pend_nxt    = pend_r;
    elapsed_nxt = elapsed_r;
    res.stepped = 1'b0;

    case (action)
      ACT_MOVE: begin
        if (move_steps[POS_W-1]) begin
          fwd_nxt  = 1'b0;
          pend_nxt = POS_W'(-move_steps);
        end else begin
          if (move_steps != '0) fwd_nxt = 1'b1;
          pend_nxt = move_steps;
        end
      end
      ACT_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (take_step) begin
          elapsed_nxt = '0;
          pos_nxt     = pos_adv;
          pend_nxt    = pend_r - POS_W'(1);
          res.stepped = 1'b1;
        end
      end
      default: ;
    endcase

    // phase table on position mod 4
    res.coil_a    = pos_nxt[1] ^ pos_nxt[0];
    res.coil_b    = ~pos_nxt[1];
    res.busy_res  = (pend_nxt != '0);
    res.position  = pos_nxt;
    res.remaining = pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fwd_r     <= 1'b0;
      pend_r    <= '0;
      elapsed_r <= TIMER_MAX;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      fwd_r     <= fwd_nxt;
      pend_r    <= pend_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end
endmodule

// ----- hw/rtl/ssq_out_reg.sv -----
// ssq_out_reg: result register holding one beat until the receiver takes it
// depends on ssq_pkg

module ssq_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  ssq_pkg::res_t load_data,
  input  logic          take,
  output logic          can_load,
  output logic          valid,
  output ssq_pkg::res_t data
);
  import ssq_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  assign can_load  = !valid_r || take;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;
endmodule

// ----- hw/rtl/stepper_step_sequencer_core.sv -----
// stepper_step_sequencer_core: top level of the two-wire stepper step sequencer
// depends on ssq_pkg, ssq_in_if, ssq_out_if, ssq_cfg_if, ssq_cfg_regs,
// ssq_motion and ssq_out_reg
//
// in_ch carries one beat per item: action 0 is a one microsecond tick, action 1
// a move with a signed step count in move_steps. out_ch returns exactly one
// beat per input beat: coil levels, step flag, busy flag, position and steps
// remaining after that item. cfg_ch writes steps_per_rev (index 0) and
// step_delay_us (index 1); other indexes are ignored, cfg_ch is always ready.
// Write configuration only while no result is outstanding.
// the result is registered and is valid in the cycle after the beat is accepted
// throughput: one item per cycle unless out_ch stalls, set by the single
// result register; motion state updates in the same cycle the beat is taken
// in_ch.ready is high while the result register is empty or being emptied, so
// a stalled receiver holds one result and stops input after that
// reset (rst_n low, synchronous): position 0, reverse direction, no steps
// pending, elapsed timer saturated, registers 200 and 6000, no result held

module stepper_step_sequencer_core #(
  parameter int TIMER_WIDTH = ssq_pkg::TIMER_W_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ssq_in_if.sink   in_ch,
  ssq_out_if.source out_ch,
  ssq_cfg_if.sink  cfg_ch
);
  import ssq_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic can_load;
  logic in_accept;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = can_load;
  assign in_accept    = in_ch.valid && can_load;

  ssq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  ssq_motion #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_motion (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .action     (in_ch.action),
    .move_steps (in_ch.move_steps),
    .cfg        (cfg),
    .res        (res)
  );

  ssq_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .load_data (res),
    .take      (out_ch.ready),
    .can_load  (can_load),
    .valid     (out_ch.valid),
    .data      (res_q)
  );

  assign out_ch.coil_a    = res_q.coil_a;
  assign out_ch.coil_b    = res_q.coil_b;
  assign out_ch.stepped   = res_q.stepped;
  assign out_ch.busy_res  = res_q.busy_res;
  assign out_ch.position  = res_q.position;
  assign out_ch.remaining = res_q.remaining;
endmodule
